// ----- hw/rtl/bpf_pkg.sv -----
// Shared types and constants for the derivation path text formatter.
// Used by bpf_digits, bpf_ctrl and bip32_path_formatter; depends on nothing.
package bpf_pkg;

  localparam int MAX_PATH_DEPTH   = 10;
  localparam int DIGIT_BUFFER_LEN = 20;
  localparam int NUM_DIGITS       = 10;
  localparam int INDEX_BITS       = 31;
  localparam int BCD_BITS         = NUM_DIGITS * 4;

  localparam logic [15:0] CAPACITY_RESET = 16'd64;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_APOS  = 8'h27;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [31:0] component_value;
    logic        last_component;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       path_done;
    logic       space_error;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic                  advance;
    logic [INDEX_BITS-1:0] value;
  } dig_ctrl_t;

  typedef struct packed {
    logic       ready;
    logic [3:0] digit;
    logic [3:0] remaining;
  } dig_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_DIGIT,
    ST_APOS,
    ST_TERM,
    ST_ERROR,
    ST_END
  } state_t;

endpackage

// ----- hw/rtl/bpf_digits.sv -----
// Binary to decimal conversion unit, one shift-add-3 step per cycle,
// then hands out digits most significant first. Depends on bpf_pkg.
module bpf_digits (
  input  logic              clk,
  input  logic              rst,
  input  bpf_pkg::dig_ctrl_t ctrl,
  output bpf_pkg::dig_stat_t stat
);

  logic [bpf_pkg::BCD_BITS-1:0]   bcd;
  logic [bpf_pkg::BCD_BITS-1:0]   bcd_adj;
  logic [bpf_pkg::INDEX_BITS-1:0] bin;
  logic [4:0]                     bit_cnt;
  logic [3:0]                     remaining;

  always_comb begin
    for (int i = 0; i < bpf_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt   <= 5'd0;
      remaining <= 4'd0;
    end else if (ctrl.start) begin
      bin       <= ctrl.value;
      bcd       <= '0;
      bit_cnt   <= 5'(bpf_pkg::INDEX_BITS);
      remaining <= 4'(bpf_pkg::NUM_DIGITS);
    end else if (bit_cnt != 5'd0) begin
      bcd     <= {bcd_adj[bpf_pkg::BCD_BITS-2:0], bin[bpf_pkg::INDEX_BITS-1]};
      bin     <= {bin[bpf_pkg::INDEX_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - 5'd1;
    end else if (ctrl.advance) begin
      bcd       <= {bcd[bpf_pkg::BCD_BITS-5:0], 4'd0};
      remaining <= remaining - 4'd1;
    end
  end

  assign stat.ready     = (bit_cnt == 5'd0);
  assign stat.digit     = bcd[bpf_pkg::BCD_BITS-1 -: 4];
  assign stat.remaining = remaining;

endmodule

// ----- hw/rtl/bpf_ctrl.sv -----
// Sequencer for one path component: space check, digit emission, suffixes,
// path state and the output register. Depends on bpf_pkg and bpf_digits.
module bpf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        capacity,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output bpf_pkg::out_item_t out_item
);

  bpf_pkg::state_t    state, state_next;
  bpf_pkg::dig_ctrl_t dctl;
  bpf_pkg::dig_stat_t dstat;
  bpf_pkg::out_item_t out_item_next;

  logic        out_valid_next;
  logic [15:0] char_offset, char_offset_next;
  logic [4:0]  component_index, component_index_next;
  logic        error_latched, error_latched_next;
  logic        last_q, last_q_next;
  logic        hard_q, hard_q_next;
  logic [3:0]  n_chars, n_chars_next;
  logic        slot_free;
  logic        space_fail;

  bpf_digits u_digits (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dctl),
    .stat (dstat)
  );

  assign slot_free  = !out_valid || out_ready;
  assign space_fail = ({1'b0, char_offset} + 17'(bpf_pkg::DIGIT_BUFFER_LEN + 1))
                      > {1'b0, capacity};
  assign in_ready   = (state == bpf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= bpf_pkg::ST_IDLE;
      out_valid       <= 1'b0;
      char_offset     <= 16'd0;
      component_index <= 5'd0;
      error_latched   <= 1'b0;
    end else begin
      state           <= state_next;
      out_valid       <= out_valid_next;
      char_offset     <= char_offset_next;
      component_index <= component_index_next;
      error_latched   <= error_latched_next;
    end
    out_item <= out_item_next;
    last_q   <= last_q_next;
    hard_q   <= hard_q_next;
    n_chars  <= n_chars_next;
  end

  always_comb begin
    state_next           = state;
    out_valid_next       = out_valid;
    out_item_next        = out_item;
    char_offset_next     = char_offset;
    component_index_next = component_index;
    error_latched_next   = error_latched;
    last_q_next          = last_q;
    hard_q_next          = hard_q;
    n_chars_next         = n_chars;
    dctl.start           = 1'b0;
    dctl.advance         = 1'b0;
    dctl.value           = in_item.component_value[bpf_pkg::INDEX_BITS-1:0];

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      bpf_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (error_latched) begin
            if (in_item.last_component) begin
              char_offset_next     = 16'd0;
              component_index_next = 5'd0;
              error_latched_next   = 1'b0;
            end
          end else if (component_index >= 5'(bpf_pkg::MAX_PATH_DEPTH)) begin
            if (in_item.last_component) begin
              state_next           = bpf_pkg::ST_END;
              char_offset_next     = 16'd0;
              component_index_next = 5'd0;
            end
          end else if (space_fail) begin
            state_next = bpf_pkg::ST_ERROR;
            if (in_item.last_component) begin
              char_offset_next     = 16'd0;
              component_index_next = 5'd0;
            end else begin
              error_latched_next = 1'b1;
            end
          end else begin
            dctl.start   = 1'b1;
            last_q_next  = in_item.last_component;
            hard_q_next  = in_item.component_value[31];
            n_chars_next = 4'd0;
            state_next   = bpf_pkg::ST_CONV;
          end
        end
      end
      bpf_pkg::ST_CONV: begin
        if (dstat.ready) begin
          state_next = bpf_pkg::ST_SKIP;
        end
      end
      bpf_pkg::ST_SKIP: begin
        if (dstat.digit == 4'd0 && dstat.remaining > 4'd1) begin
          dctl.advance = 1'b1;
        end else begin
          state_next = bpf_pkg::ST_DIGIT;
        end
      end
      bpf_pkg::ST_DIGIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_item_next  = '{out_char: bpf_pkg::CHAR_ZERO | {4'd0, dstat.digit},
                             run_last: 1'b0, path_done: 1'b0, space_error: 1'b0};
          n_chars_next   = n_chars + 4'd1;
          if (dstat.remaining == 4'd1) begin
            state_next = hard_q ? bpf_pkg::ST_APOS : bpf_pkg::ST_TERM;
          end else begin
            dctl.advance = 1'b1;
          end
        end
      end
      bpf_pkg::ST_APOS: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_item_next  = '{out_char: bpf_pkg::CHAR_APOS,
                             run_last: 1'b0, path_done: 1'b0, space_error: 1'b0};
          n_chars_next   = n_chars + 4'd1;
          state_next     = bpf_pkg::ST_TERM;
        end
      end
      bpf_pkg::ST_TERM: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          state_next     = bpf_pkg::ST_IDLE;
          if (last_q) begin
            out_item_next        = '{out_char: bpf_pkg::CHAR_NUL,
                                     run_last: 1'b1, path_done: 1'b1, space_error: 1'b0};
            char_offset_next     = 16'd0;
            component_index_next = 5'd0;
          end else begin
            out_item_next        = '{out_char: bpf_pkg::CHAR_SLASH,
                                     run_last: 1'b1, path_done: 1'b0, space_error: 1'b0};
            char_offset_next     = char_offset + {12'd0, n_chars} + 16'd1;
            component_index_next = component_index + 5'd1;
          end
        end
      end
      bpf_pkg::ST_ERROR: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_item_next  = '{out_char: bpf_pkg::CHAR_NUL,
                             run_last: 1'b1, path_done: 1'b0, space_error: 1'b1};
          state_next     = bpf_pkg::ST_IDLE;
        end
      end
      bpf_pkg::ST_END: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_item_next  = '{out_char: bpf_pkg::CHAR_NUL,
                             run_last: 1'b1, path_done: 1'b1, space_error: 1'b0};
          state_next     = bpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpf_pkg::ST_IDLE;
      end
    endcase
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.path_done |-> out_item.run_last)
    else $error("Path terminator not marked as the last result of its item.");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.space_error |->
      out_item.run_last && !out_item.path_done && out_item.out_char == bpf_pkg::CHAR_NUL)
    else $error("Space error result has the wrong form.");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    component_index <= 5'(bpf_pkg::MAX_PATH_DEPTH))
    else $error("Component index exceeded the depth bound.");

  a_error_below_depth: assert property (@(posedge clk) disable iff (rst)
    error_latched |-> component_index < 5'(bpf_pkg::MAX_PATH_DEPTH))
    else $error("Error latched beyond the depth bound.");

  a_digit_after_conv: assert property (@(posedge clk) disable iff (rst)
    state == bpf_pkg::ST_DIGIT |-> dstat.ready && dstat.remaining != 4'd0)
    else $error("Digit emitted before conversion finished.");

endmodule

// ----- hw/rtl/bip32_path_formatter.sv -----
// Each item carries one derivation path component and is turned into its text,
// one character per result item: the decimal index with no leading zeros, an
// apostrophe when hardened, then '/' or a terminating NUL. For a formatted
// component the shift-add-3 conversion unit runs 31 steps, leading zeros are
// dropped one per cycle, and the output register moves one character per cycle
// while the output is not stalled. Error and depth-bound items yield at most a
// single NUL result. Depends on bpf_pkg and bpf_ctrl.
module bip32_path_formatter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output bpf_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] capacity;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bpf_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && paddr[2] == bpf_pkg::REG_CAPACITY) begin
      capacity <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == bpf_pkg::REG_CAPACITY) ? {16'd0, capacity} : 32'd0;

  bpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
